// File: rtl/ffba_pkg.sv
// shared constants for the first-fit block allocator
package ffba_pkg;

   localparam int ARENA_UNITS_DEF = 65536;
   localparam int UNIT_BYTES      = 16;
   localparam int UNIT_SHIFT      = 4;

   localparam int FUNC_W   = 1;
   localparam int BYTES_W  = 21;
   localparam int ADDR_W   = 32;
   localparam int PAY_W    = 20;
   localparam int STAT_W   = 2;
   localparam int WANT_W   = 18;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_ROOM = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_BLK = 2'd3;

endpackage

// File: rtl/ffba_tag_ram.sv
// block tag memory with a clearing pass after reset
module ffba_tag_ram
   import ffba_pkg::*;
#(
   parameter int ARENA_UNITS = ARENA_UNITS_DEF,
   parameter int AW          = $clog2(ARENA_UNITS),
   parameter int SW          = $clog2(ARENA_UNITS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] addr,
   input  logic          wr_en,
   input  logic [SW+1:0] wdata,
   output logic [SW+1:0] rdata,
   output logic          ready
);

   logic [SW+1:0] mem [ARENA_UNITS];
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clearing_ff, clearing_in;
   logic [SW+1:0] rdata_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [SW+1:0] mem_wd;

   always_comb begin
      clr_addr_in = clr_addr_ff + 1'b1;
      clearing_in = clearing_ff && (clr_addr_ff != AW'(ARENA_UNITS - 1));
      if (clearing_ff) begin
         mem_addr = clr_addr_ff;
         mem_we   = 1'b1;
         if (clr_addr_ff == AW'(1)) begin
            mem_wd = {1'b1, 1'b0, SW'(ARENA_UNITS - 1)};
         end else begin
            mem_wd = '0;
         end
      end else begin
         mem_addr = addr;
         mem_we   = wr_en;
         mem_wd   = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      rdata_ff <= mem[mem_addr];
   end

   assign rdata = rdata_ff;
   assign ready = !clearing_ff;

endmodule

// File: rtl/first_fit_block_allocator_core.sv
// first-fit block allocator: chain walk, split and merge control
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | func, request_bytes, block_address
//  rsp     | out       | rsp_valid/stall  | payload_address, status
//
// allocate: reads and checks each block of the chain in the tag memory in turn, then
// marks the first free fit used, splitting off the rest when it is 2 units or more;
// free: checks the block header, marks it free, then walks the whole chain and merges
// each free run into its first block; one tag memory port; one transaction at a time
// after reset a clearing pass over the whole tag memory runs before req is taken
// a stalled rsp holds its result; the next req is taken meanwhile
module first_fit_block_allocator_core
   import ffba_pkg::*;
#(
   parameter int ARENA_UNITS = ARENA_UNITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0]  req_block_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PAY_W-1:0]   rsp_payload_address,
   output logic [STAT_W-1:0]  rsp_status
);

   localparam int AW = $clog2(ARENA_UNITS);
   localparam int SW = $clog2(ARENA_UNITS + 1);
   localparam int NW = SW + 1;
   localparam int CW = ((SW > WANT_W) ? SW : WANT_W) + 1;
   localparam int PW = AW + UNIT_SHIFT + 1;
   localparam logic [35:0] REGION_BYTES = 36'(ARENA_UNITS) * 36'(UNIT_BYTES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ARD  = 4'd1;
   localparam logic [3:0] S_AEV  = 4'd2;
   localparam logic [3:0] S_AWB  = 4'd3;
   localparam logic [3:0] S_FRD  = 4'd4;
   localparam logic [3:0] S_FEV  = 4'd5;
   localparam logic [3:0] S_MRW  = 4'd6;
   localparam logic [3:0] S_MEW  = 4'd7;
   localparam logic [3:0] S_MEN  = 4'd8;
   localparam logic [3:0] S_MNX  = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [AW-1:0]     b_ff, b_in;
   logic [WANT_W-1:0] want_ff, want_in;
   logic [AW-1:0]     n_ff, n_in;
   logic [SW-1:0]     units_ff, units_in;
   logic              dirty_ff, dirty_in;
   logic [PAY_W-1:0]  res_pay_ff, res_pay_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PAY_W-1:0]  rsp_pay_ff, rsp_pay_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic [AW-1:0]     mem_addr;
   logic              mem_we;
   logic [SW+1:0]     mem_wd;
   logic [SW+1:0]     rdata;
   logic              mem_ready;

   logic              rd_start, rd_used;
   logic [SW-1:0]     rd_units;
   logic [NW-1:0]     nxt_rd, nxt_units;
   logic [CW-1:0]     want_c, size_c;
   logic [PW-1:0]     pay_full;
   logic [WANT_W-1:0] req_want;
   logic [AW-1:0]     req_hdr;
   logic              accept, slot_free;

   ffba_tag_ram #(
      .ARENA_UNITS(ARENA_UNITS),
      .AW(AW),
      .SW(SW)
   ) u_tag_ram (
      .clock(clock),
      .reset(reset),
      .addr(mem_addr),
      .wr_en(mem_we),
      .wdata(mem_wd),
      .rdata(rdata),
      .ready(mem_ready)
   );

   assign rd_start  = rdata[SW+1];
   assign rd_used   = rdata[SW];
   assign rd_units  = rdata[SW-1:0];
   assign nxt_rd    = NW'(b_ff) + NW'(rd_units);
   assign nxt_units = NW'(b_ff) + NW'(units_ff);
   assign want_c    = CW'(want_ff);
   assign size_c    = CW'(rd_units);
   assign pay_full  = (PW'(b_ff) + PW'(1)) << UNIT_SHIFT;
   assign req_want  = WANT_W'((23'(req_request_bytes) + 23'(UNIT_BYTES - 1)) >> UNIT_SHIFT)
                      + WANT_W'(1);
   assign req_hdr   = AW'((req_block_address >> UNIT_SHIFT) - 32'd1);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && mem_ready);

   always_comb begin
      state_in    = state_ff;
      b_in        = b_ff;
      want_in     = want_ff;
      n_in        = n_ff;
      units_in    = units_ff;
      dirty_in    = dirty_ff;
      res_pay_in  = res_pay_ff;
      res_stat_in = res_stat_ff;
      mem_addr    = b_ff;
      mem_we      = 1'b0;
      mem_wd      = rdata;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_pay_in = '0;
               state_in   = S_RESP;
               if (req_func == FUNC_ALLOC) begin
                  want_in = req_want;
                  b_in    = AW'(1);
                  if (req_request_bytes == '0) begin
                     res_stat_in = STAT_NO_ROOM;
                  end else begin
                     state_in = S_ARD;
                  end
               end else if (req_block_address == '0) begin
                  res_stat_in = STAT_OK;
               end else if ({4'b0, req_block_address} >= REGION_BYTES) begin
                  res_stat_in = STAT_RANGE;
               end else if (req_block_address[UNIT_SHIFT-1:0] != '0) begin
                  res_stat_in = STAT_NOT_BLK;
               end else begin
                  b_in     = req_hdr;
                  state_in = S_FRD;
               end
            end
         end
         S_ARD: begin
            mem_addr = b_ff;
            state_in = S_AEV;
         end
         S_AEV: begin
            if (!rd_used && (size_c >= want_c)) begin
               res_pay_in  = PAY_W'(pay_full);
               res_stat_in = STAT_OK;
               if (size_c >= want_c + CW'(2)) begin
                  mem_addr = AW'(CW'(b_ff) + want_c);
                  mem_we   = 1'b1;
                  mem_wd   = {1'b1, 1'b0, SW'(size_c - want_c)};
                  state_in = S_AWB;
               end else begin
                  mem_addr = b_ff;
                  mem_we   = 1'b1;
                  mem_wd   = {1'b1, 1'b1, rd_units};
                  state_in = S_RESP;
               end
            end else if (nxt_rd >= NW'(ARENA_UNITS)) begin
               res_pay_in  = '0;
               res_stat_in = STAT_NO_ROOM;
               state_in    = S_RESP;
            end else begin
               b_in     = AW'(nxt_rd);
               state_in = S_ARD;
            end
         end
         S_AWB: begin
            mem_addr = b_ff;
            mem_we   = 1'b1;
            mem_wd   = {1'b1, 1'b1, SW'(want_ff)};
            state_in = S_RESP;
         end
         S_FRD: begin
            mem_addr = b_ff;
            state_in = S_FEV;
         end
         S_FEV: begin
            if (!rd_start) begin
               res_stat_in = STAT_NOT_BLK;
               state_in    = S_RESP;
            end else begin
               mem_addr    = b_ff;
               mem_we      = 1'b1;
               mem_wd      = {1'b1, 1'b0, rd_units};
               res_stat_in = STAT_OK;
               b_in        = AW'(1);
               state_in    = S_MRW;
            end
         end
         S_MRW: begin
            mem_addr = b_ff;
            state_in = S_MEW;
         end
         S_MEW: begin
            if (rd_used || (nxt_rd >= NW'(ARENA_UNITS))) begin
               if (nxt_rd >= NW'(ARENA_UNITS)) begin
                  state_in = S_RESP;
               end else begin
                  b_in     = AW'(nxt_rd);
                  state_in = S_MRW;
               end
            end else begin
               units_in = rd_units;
               dirty_in = 1'b0;
               mem_addr = AW'(nxt_rd);
               n_in     = AW'(nxt_rd);
               state_in = S_MEN;
            end
         end
         S_MEN: begin
            if (!rd_used) begin
               mem_addr = n_ff;
               mem_we   = 1'b1;
               mem_wd   = '0;
               units_in = SW'(units_ff + rd_units);
               dirty_in = 1'b1;
               state_in = S_MNX;
            end else begin
               if (dirty_ff) begin
                  mem_addr = b_ff;
                  mem_we   = 1'b1;
                  mem_wd   = {1'b1, 1'b0, units_ff};
               end
               dirty_in = 1'b0;
               b_in     = n_ff;
               state_in = S_MRW;
            end
         end
         S_MNX: begin
            if (nxt_units >= NW'(ARENA_UNITS)) begin
               mem_addr = b_ff;
               mem_we   = 1'b1;
               mem_wd   = {1'b1, 1'b0, units_ff};
               state_in = S_RESP;
            end else begin
               mem_addr = AW'(nxt_units);
               n_in     = AW'(nxt_units);
               state_in = S_MEN;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pay_in   = rsp_pay_ff;
      rsp_stat_in  = rsp_stat_ff;
      if ((state_ff == S_RESP) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = res_pay_ff;
         rsp_stat_in  = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dirty_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dirty_ff     <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff        <= b_in;
      want_ff     <= want_in;
      n_ff        <= n_in;
      units_ff    <= units_in;
      res_pay_ff  <= res_pay_in;
      res_stat_ff <= res_stat_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_pay_ff;
   assign rsp_status          = rsp_stat_ff;

endmodule
